>>> design/ssdh_pkg.sv
// Shared constants and types for the subchain squared-distance histogram unit.
`default_nettype none

package ssdh_pkg;

  // Histogram geometry
  localparam int MAX_BEADS = 1024;
  localparam int BIN_W     = $clog2(MAX_BEADS);

  // Field and datapath widths
  localparam int POS_W  = 24;           // bead coordinate, 12 fraction bits
  localparam int BOX_W  = 23;           // box length, 12 fraction bits
  localparam int DIFF_W = POS_W + 2;    // bond component after one wrap
  localparam int RUN_W  = 32;           // running end-to-end component
  localparam int SQ_W   = 63;           // squared length and bin totals

  localparam int CFG_IDX_W = 2;
  localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(4096);

  // Stream payload widths
  localparam int IN_DATA_W  = 3 * POS_W;
  localparam int OUT_DATA_W = BIN_W + 2 * SQ_W;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic        [BOX_W-1:0]  box_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [RUN_W-1:0]  run_t;
  typedef logic        [SQ_W-1:0]   sq_t;
  typedef logic        [BIN_W-1:0]  bin_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X = 2'd0,
    CFG_BOX_Y = 2'd1,
    CFG_BOX_Z = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

>>> design/ssdh_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module ssdh_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/subchain_squared_distance_histogram_unit.sv
// Top level of the subchain squared-distance histogram unit.
//
// Beads stream in on s_axis one per transfer, in chain order, with tuser set on
// the first bead of each chain. The unit sustains one bead per clock unless
// m_axis stalls or the clear runs: bond vector, running end-to-end vector,
// squares, sum and the histogram read-modify-write each take one pipeline
// stage, the last being the m_axis output register. The histogram lives in
// one 1024 x 63 RAM with one write and one registered read port; a write
// still in the output register is forwarded to the next read of the same
// bin. After reset the unit sweeps the RAM to zero, one bin a cycle, and
// s_axis_tready stays low until the sweep is done; configuration writes are
// taken at any time but belong only to idle periods.
`default_nettype none

module subchain_squared_distance_histogram_unit
  import ssdh_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input beads
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // pos_x, pos_y, pos_z
  input  wire logic [0:0]            s_axis_tuser,  // chain_start
  // Results
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // bin_index, squared_distance, bin_total
  // Configuration writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [BOX_W-1:0]      cfg_data_i
);

  // Minimum-image bond component, one wrap, a half box flips its sign
  function automatic diff_t min_image(pos_t cur, pos_t prv, box_t len);
    diff_t                   d;
    logic signed [DIFF_W:0]  d2;
    logic signed [DIFF_W:0]  l2;
    diff_t                   lw;
    d  = DIFF_W'(cur) - DIFF_W'(prv);
    d2 = $signed({d, 1'b0});
    l2 = $signed((DIFF_W+1)'(len));
    lw = $signed(DIFF_W'(len));
    if (d2 >= l2) begin
      d = d - lw;
    end else if (d2 <= -l2) begin
      d = d + lw;
    end
    return d;
  endfunction

  // Saturating add into a running component
  function automatic run_t sat_run(run_t run, diff_t d);
    logic signed [RUN_W:0] s;
    s = (RUN_W+1)'(run) + (RUN_W+1)'(d);
    if (s[RUN_W] != s[RUN_W-1]) begin
      return s[RUN_W] ? {1'b1, {(RUN_W-1){1'b0}}} : {1'b0, {(RUN_W-1){1'b1}}};
    end
    return s[RUN_W-1:0];
  endfunction

  // Square of a component magnitude
  function automatic sq_t sq_mag(run_t v);
    logic [RUN_W-1:0]   mag;
    logic [2*RUN_W-1:0] prod;
    mag  = v[RUN_W-1] ? RUN_W'(-v) : RUN_W'(v);
    prod = mag * mag;
    return prod[SQ_W-1:0];
  endfunction

  // Handshake and pipeline advance
  logic adv;
  logic in_xfer;
  logic clearing_q;
  logic [BIN_W-1:0] clr_addr_q;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !clearing_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Input unpack
  pos_t in_x, in_y, in_z;
  assign in_x = s_axis_tdata[POS_W-1:0];
  assign in_y = s_axis_tdata[2*POS_W-1:POS_W];
  assign in_z = s_axis_tdata[3*POS_W-1:2*POS_W];

  // Box length registers
  box_t box_x_q, box_y_q, box_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q <= BOX_RESET;
      box_y_q <= BOX_RESET;
      box_z_q <= BOX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BOX_X: box_x_q <= cfg_data_i;
        CFG_BOX_Y: box_y_q <= cfg_data_i;
        CFG_BOX_Z: box_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage A: bond vector from the previous bead
  pos_t  prev_x_q, prev_y_q, prev_z_q;
  logic  a_valid_q, a_start_q;
  diff_t a_dx_q, a_dy_q, a_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      prev_z_q  <= '0;
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_xfer;
      if (in_xfer) begin
        prev_x_q <= in_x;
        prev_y_q <= in_y;
        prev_z_q <= in_z;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_start_q <= s_axis_tuser[0];
      a_dx_q    <= min_image(in_x, prev_x_q, box_x_q);
      a_dy_q    <= min_image(in_y, prev_y_q, box_y_q);
      a_dz_q    <= min_image(in_z, prev_z_q, box_z_q);
    end
  end

  // Stage B: running vector and bead position
  logic b_valid_q;
  run_t run_x_q, run_y_q, run_z_q;
  bin_t count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      run_x_q   <= '0;
      run_y_q   <= '0;
      run_z_q   <= '0;
      count_q   <= '0;
    end else if (adv) begin
      b_valid_q <= a_valid_q;
      if (a_valid_q) begin
        if (a_start_q) begin
          run_x_q <= '0;
          run_y_q <= '0;
          run_z_q <= '0;
          count_q <= '0;
        end else begin
          run_x_q <= sat_run(run_x_q, a_dx_q);
          run_y_q <= sat_run(run_y_q, a_dy_q);
          run_z_q <= sat_run(run_z_q, a_dz_q);
          if (count_q != BIN_W'(MAX_BEADS - 1)) begin
            count_q <= count_q + BIN_W'(1);
          end
        end
      end
    end
  end

  // Stage C: component squares
  logic c_valid_q;
  sq_t  c_sqx_q, c_sqy_q, c_sqz_q;
  bin_t c_bin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && b_valid_q) begin
      c_sqx_q <= sq_mag(run_x_q);
      c_sqy_q <= sq_mag(run_y_q);
      c_sqz_q <= sq_mag(run_z_q);
      c_bin_q <= count_q;
    end
  end

  // Stage D: saturating sum, histogram read in flight
  logic        d_valid_q;
  sq_t         d_sq_q;
  bin_t        d_bin_q;
  logic [63:0] sum3;

  assign sum3 = 64'(c_sqx_q) + 64'(c_sqy_q) + 64'(c_sqz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (adv) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && c_valid_q) begin
      d_sq_q  <= sum3[63] ? '1 : sum3[SQ_W-1:0];
      d_bin_q <= c_bin_q;
    end
  end

  // Histogram memory
  logic ram_we;
  bin_t ram_waddr;
  sq_t  ram_wdata;
  sq_t  ram_rdata;

  // Output register, also the forwarding source for the last write
  logic        fwd_valid_q;
  bin_t        m_bin_q;
  sq_t         m_sq_q;
  sq_t         m_total_q;
  sq_t         base;
  logic [63:0] total_sum;
  sq_t         total;

  assign base      = (fwd_valid_q && (m_bin_q == d_bin_q)) ? m_total_q : ram_rdata;
  assign total_sum = 64'(base) + 64'(d_sq_q);
  assign total     = total_sum[63] ? '1 : total_sum[SQ_W-1:0];

  assign ram_we    = clearing_q || (adv && d_valid_q);
  assign ram_waddr = clearing_q ? clr_addr_q : d_bin_q;
  assign ram_wdata = clearing_q ? '0 : total;

  ssdh_ram #(
    .WIDTH (SQ_W),
    .DEPTH (MAX_BEADS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (adv && c_valid_q),
    .raddr_i (c_bin_q),
    .rdata_o (ram_rdata)
  );

  // Clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + BIN_W'(1);
      if (clr_addr_q == BIN_W'(MAX_BEADS - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
      fwd_valid_q   <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= d_valid_q;
      fwd_valid_q   <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && d_valid_q) begin
      m_bin_q   <= d_bin_q;
      m_sq_q    <= d_sq_q;
      m_total_q <= total;
    end
  end

  assign m_axis_tdata = {m_total_q, m_sq_q, m_bin_q};

`ifndef SYNTH
  // No bead enters while the histogram is being swept
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s_axis_tready)
    else $error("bead accepted during histogram clear");

  // Only a chain's first bead lands in bin zero, and it adds nothing
  a_bin_zero_no_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_bin_q == '0)) |-> (m_sq_q == '0))
    else $error("nonzero squared distance in bin zero");

  // A bin total always includes its own contribution
  a_total_covers_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_total_q >= m_sq_q))
    else $error("bin total below squared distance");

  // The sweep never overlaps pipeline traffic
  a_clear_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !(a_valid_q || b_valid_q || c_valid_q || d_valid_q))
    else $error("pipeline busy during histogram clear");
`endif

endmodule

`default_nettype wire
